>>> sv/vector_load_data_formatter_defines.svh
// ----------------------------------------------------------------------------
// vector load data formatter assertion macros
// shared property forms for the formatter checks
// ----------------------------------------------------------------------------
`ifndef VECTOR_LOAD_DATA_FORMATTER_DEFINES_SVH
`define VECTOR_LOAD_DATA_FORMATTER_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define VLDF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vldf check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define VLDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vldf check failed");

`endif

>>> sv/vldf_pkg.sv
// ----------------------------------------------------------------------------
// vldf_pkg
// types, codes and helper functions of the vector load data formatter
// ----------------------------------------------------------------------------
package vldf_pkg;

    localparam int WIDE_ACCESS_BYTES = 32;
    localparam int LANE_STRIDE       = 8;
    localparam int LANE_SLOTS        = 8;

    // element type codes
    localparam logic [3:0] ET_B8  = 4'd0;
    localparam logic [3:0] ET_U8  = 4'd1;
    localparam logic [3:0] ET_S8  = 4'd2;
    localparam logic [3:0] ET_B16 = 4'd3;
    localparam logic [3:0] ET_U16 = 4'd4;
    localparam logic [3:0] ET_S16 = 4'd5;
    localparam logic [3:0] ET_B32 = 4'd6;
    localparam logic [3:0] ET_U32 = 4'd7;
    localparam logic [3:0] ET_S32 = 4'd8;
    localparam logic [3:0] ET_F32 = 4'd9;
    localparam logic [3:0] ET_B64 = 4'd10;
    localparam logic [3:0] ET_U64 = 4'd11;
    localparam logic [3:0] ET_S64 = 4'd12;
    localparam logic [3:0] ET_F64 = 4'd13;

    // destination width codes
    localparam logic [2:0] WC_B8   = 3'd0;
    localparam logic [2:0] WC_B16  = 3'd1;
    localparam logic [2:0] WC_B32  = 3'd2;
    localparam logic [2:0] WC_B64  = 3'd3;
    localparam logic [2:0] WC_B128 = 3'd4;
    localparam logic [2:0] WC_PRED = 3'd5;

    // vector modes
    localparam logic [1:0] VM_SCALAR = 2'd0;

    // element size log2 codes
    localparam logic [1:0] ES_1 = 2'd0;
    localparam logic [1:0] ES_2 = 2'd1;
    localparam logic [1:0] ES_4 = 2'd2;
    localparam logic [1:0] ES_8 = 2'd3;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_SHAPE  = 2'd1,
        FAULT_NARROW = 2'd2,
        FAULT_DECL   = 2'd3
    } t_fault;

    typedef struct packed {
        logic [63:0] mem_data_0;
        logic [63:0] mem_data_1;
        logic [63:0] mem_data_2;
        logic [63:0] mem_data_3;
        logic [3:0]  elem_type;
        logic [1:0]  vector_mode;
        logic        vector_form;
        logic        space_wide_ok;
        logic [3:0]  dest_count;
        logic [7:0]  dest_present;
        logic [23:0] dest_widths;
    } t_req;

    typedef struct packed {
        logic [2:0]  lane_index;
        logic        write_enable;
        logic [63:0] value_low;
        logic [63:0] value_high;
        logic [2:0]  value_width;
        t_fault      fault_code;
        logic        last;
    } t_rsp;

    // bit 2: type supported, bits 1:0: log2 of element bytes
    function automatic logic [2:0] elem_info(input logic [3:0] etype);
        logic [2:0] res;
        case (etype)
            ET_B8, ET_U8, ET_S8:              res = {1'b1, ES_1};
            ET_B16, ET_U16, ET_S16:           res = {1'b1, ES_2};
            ET_B32, ET_U32, ET_S32, ET_F32:   res = {1'b1, ES_4};
            ET_B64, ET_U64, ET_S64, ET_F64:   res = {1'b1, ES_8};
            default:                          res = 3'b000;
        endcase
        return res;
    endfunction

    function automatic logic elem_signed(input logic [3:0] etype);
        return (etype == ET_S8) || (etype == ET_S16) || (etype == ET_S32) ||
               (etype == ET_S64);
    endfunction

    // register capacity in bytes is 1 << wcode for the plain widths
    function automatic t_fault lane_check(input logic [2:0] wcode, input logic [1:0] elog);
        t_fault res;
        if (wcode > WC_PRED) begin
            res = FAULT_DECL;
        end else if (wcode == WC_PRED || wcode < {1'b0, elog}) begin
            res = FAULT_NARROW;
        end else begin
            res = FAULT_NONE;
        end
        return res;
    endfunction

endpackage

>>> sv/vector_load_data_formatter.sv
// ----------------------------------------------------------------------------
// vector_load_data_formatter
// checks the shape of a load and returns one sign- or zero-extended
// result per destination lane, or one fault result
//
//   channel   handshake                      payload
//   request   i_req_valid / o_req_ready      i_req (vldf_pkg::t_req)
//   result    o_rsp_valid / i_rsp_ready      o_rsp (vldf_pkg::t_rsp)
//
// a request is checked as it enters the lane register and then issues one
// result per cycle into the output register unless the result is stalled:
// one for a fault or scalar, up to 8 for a v8 load; there is one result port
// the next request enters in the cycle the final lane moves out
// synchronous active-low reset clears both valid flags
// a stalled result holds the output register and the lane register
// ----------------------------------------------------------------------------
`include "vector_load_data_formatter_defines.svh"

module vector_load_data_formatter #(
    parameter int MAX_LANES        = 8,
    parameter int MAX_ACCESS_BYTES = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  vldf_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output vldf_pkg::t_rsp  o_rsp
);

    localparam int DATA_W = MAX_ACCESS_BYTES * 8;
    localparam int PAD_W  = DATA_W + 64;

    // request checks
    logic [2:0]       c_info;
    logic [1:0]       c_elog;
    logic [3:0]       c_lanes;
    logic [2:0]       c_total_log2;
    logic [6:0]       c_total;
    logic             c_wide;
    logic             c_found;
    vldf_pkg::t_fault c_lf;
    vldf_pkg::t_fault c_fault;
    logic [255:0]     c_bytes;

    // lane register
    logic                     r_a_valid;
    logic [2:0]               r_a_lane;
    logic [2:0]               r_a_last_lane;
    vldf_pkg::t_fault         r_a_fault;
    logic [1:0]               r_a_elog;
    logic                     r_a_sgn;
    logic [7:0]               r_a_present;
    logic [23:0]              r_a_widths;
    logic [DATA_W-1:0]        r_a_data;

    // output register
    logic                     r_rsp_valid;
    vldf_pkg::t_rsp           r_rsp;
    vldf_pkg::t_rsp           n_rsp;

    logic       out_free;
    logic       a_final;
    logic       a_move;
    logic       req_accept;
    logic [2:0] lane_w [vldf_pkg::LANE_SLOTS];
    logic [2:0] wcode;
    logic [4:0] byte_off;
    logic [7:0] bit_off;
    logic [PAD_W-1:0] padded;
    logic [PAD_W-1:0] shifted;
    logic [63:0] elem;
    logic [63:0] mask;
    logic        msb;
    logic        neg;
    logic [63:0] ext;

    assign out_free    = !r_rsp_valid || i_rsp_ready;
    assign a_final     = (r_a_lane == r_a_last_lane);
    assign a_move      = r_a_valid && out_free;
    assign o_req_ready = !r_a_valid || (out_free && a_final);
    assign req_accept  = i_req_valid && o_req_ready;

    assign c_bytes = {i_req.mem_data_3, i_req.mem_data_2, i_req.mem_data_1, i_req.mem_data_0};

    always_comb begin
        c_info       = vldf_pkg::elem_info(i_req.elem_type);
        c_elog       = c_info[1:0];
        c_lanes      = 4'd1 << i_req.vector_mode;
        c_total_log2 = {1'b0, c_elog} + {1'b0, i_req.vector_mode};
        c_total      = 7'd1 << c_total_log2;
        c_wide       = (c_total == 7'(vldf_pkg::WIDE_ACCESS_BYTES));
        c_found      = 1'b0;
        c_lf         = vldf_pkg::FAULT_NONE;
        c_fault      = vldf_pkg::FAULT_NONE;
        if (!c_info[2] || c_lanes > 4'(MAX_LANES) ||
            (c_lanes == 4'(vldf_pkg::LANE_STRIDE) && c_elog != vldf_pkg::ES_4)) begin
            c_fault = vldf_pkg::FAULT_SHAPE;
        end else if (c_total > 7'(MAX_ACCESS_BYTES)) begin
            c_fault = vldf_pkg::FAULT_SHAPE;
        end else if (!i_req.vector_form) begin
            c_lf = vldf_pkg::lane_check(i_req.dest_widths[2:0], c_elog);
            if (i_req.vector_mode != vldf_pkg::VM_SCALAR) begin
                c_fault = vldf_pkg::FAULT_SHAPE;
            end else if (c_lf != vldf_pkg::FAULT_NONE) begin
                c_fault = c_lf;
            end else if (c_wide && !i_req.space_wide_ok) begin
                c_fault = vldf_pkg::FAULT_SHAPE;
            end
        end else if (i_req.vector_mode == vldf_pkg::VM_SCALAR ||
                     i_req.dest_count != c_lanes) begin
            c_fault = vldf_pkg::FAULT_SHAPE;
        end else begin
            for (int k = 0; k < vldf_pkg::LANE_SLOTS; k++) begin
                if (!c_found && 4'(k) < c_lanes) begin
                    if (!i_req.dest_present[k]) begin
                        if (!c_wide) begin
                            c_fault = vldf_pkg::FAULT_SHAPE;
                            c_found = 1'b1;
                        end
                    end else if (vldf_pkg::lane_check(i_req.dest_widths[3*k +: 3], c_elog)
                                 != vldf_pkg::FAULT_NONE) begin
                        c_fault = vldf_pkg::lane_check(i_req.dest_widths[3*k +: 3], c_elog);
                        c_found = 1'b1;
                    end
                end
            end
            if (!c_found && c_wide && !i_req.space_wide_ok) begin
                c_fault = vldf_pkg::FAULT_SHAPE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_lane  <= 3'd0;
        end else if (req_accept) begin
            r_a_valid <= 1'b1;
            r_a_lane  <= 3'd0;
        end else if (a_move) begin
            if (a_final) begin
                r_a_valid <= 1'b0;
            end else begin
                r_a_lane <= r_a_lane + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_a_fault     <= c_fault;
            r_a_last_lane <= (c_fault != vldf_pkg::FAULT_NONE) ? 3'd0 : 3'(c_lanes - 4'd1);
            r_a_elog      <= c_elog;
            r_a_sgn       <= vldf_pkg::elem_signed(i_req.elem_type);
            r_a_present   <= i_req.vector_form ? i_req.dest_present : 8'h01;
            r_a_widths    <= i_req.dest_widths;
            r_a_data      <= c_bytes[DATA_W-1:0];
        end
    end

    // lane formatting
    always_comb begin
        for (int k = 0; k < vldf_pkg::LANE_SLOTS; k++) begin
            lane_w[k] = r_a_widths[3*k +: 3];
        end
        wcode    = lane_w[r_a_lane];
        byte_off = 5'({2'b00, r_a_lane} << r_a_elog);
        bit_off  = {byte_off, 3'b000};
        padded   = {64'd0, r_a_data};
        shifted  = padded >> bit_off;
        elem     = shifted[63:0];
        case (r_a_elog)
            vldf_pkg::ES_1: begin
                mask = 64'h0000_0000_0000_00FF;
                msb  = elem[7];
            end
            vldf_pkg::ES_2: begin
                mask = 64'h0000_0000_0000_FFFF;
                msb  = elem[15];
            end
            vldf_pkg::ES_4: begin
                mask = 64'h0000_0000_FFFF_FFFF;
                msb  = elem[31];
            end
            default: begin
                mask = 64'hFFFF_FFFF_FFFF_FFFF;
                msb  = elem[63];
            end
        endcase
        neg = r_a_sgn && msb;
        ext = (elem & mask) | (neg ? ~mask : 64'd0);

        n_rsp              = '0;
        n_rsp.lane_index   = r_a_lane;
        n_rsp.last         = a_final;
        n_rsp.fault_code   = vldf_pkg::FAULT_NONE;
        if (r_a_fault != vldf_pkg::FAULT_NONE) begin
            n_rsp.lane_index = 3'd0;
            n_rsp.fault_code = r_a_fault;
            n_rsp.last       = 1'b1;
        end else if (r_a_present[r_a_lane]) begin
            n_rsp.write_enable = 1'b1;
            n_rsp.value_width  = wcode;
            case (wcode)
                vldf_pkg::WC_B8:   n_rsp.value_low = {56'd0, ext[7:0]};
                vldf_pkg::WC_B16:  n_rsp.value_low = {48'd0, ext[15:0]};
                vldf_pkg::WC_B32:  n_rsp.value_low = {32'd0, ext[31:0]};
                vldf_pkg::WC_B128: begin
                    n_rsp.value_low  = ext;
                    n_rsp.value_high = neg ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
                end
                default:           n_rsp.value_low = ext;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (a_move) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `VLDF_ASSERT_NOW(a_fault_is_final, o_rsp_valid && (o_rsp.fault_code != vldf_pkg::FAULT_NONE), o_rsp.last && !o_rsp.write_enable)
    `VLDF_ASSERT_NOW(a_busy_blocks_req, r_a_valid && !a_final, !o_req_ready)
    `VLDF_ASSERT_NEXT(a_lane_follows, o_rsp_valid && i_rsp_ready && !o_rsp.last, o_rsp_valid && (o_rsp.lane_index == 3'($past(o_rsp.lane_index) + 3'd1)))

endmodule
